// ===== sv/spg_pkg.sv =====
// Shared types and constants for the superellipse point generator.
// Fixed-point formats, stage counts and series divisors; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

  // Fraction bits of the cos, sin and power magnitudes (unsigned Q1.FB).
  localparam int FB      = 15;
  localparam int MAG_W   = FB + 1;
  // Width of a Q30 value that may reach 1.0.
  localparam int Q_W     = 31;
  localparam logic [Q_W-1:0] Q_ONE     = 31'h4000_0000;
  localparam logic [Q_W-1:0] Q_HALF_PI = 31'd1686629713;
  localparam logic [29:0]    Q_LN2     = 30'd744261118;

  // Register widths.
  localparam int AXIS_W  = 12;
  localparam int EXP_W   = 16;
  localparam int EXP_FRAC = 12;
  localparam int CFG_W   = 16;
  localparam int PT_W    = 14;

  // Logarithm and exponential formats.
  localparam int LOG_FRAC_BITS = 16;
  localparam int SHW     = $clog2(FB + 1);
  localparam int LGW     = SHW + LOG_FRAC_BITS;
  localparam int PW      = LGW + EXP_W - EXP_FRAC;
  localparam int IPW     = PW - LOG_FRAC_BITS;

  // Series terms and their divisors, in evaluation order.
  localparam int SINE_TERMS = 4;
  localparam int EXP_TERMS  = 7;
  localparam int SINE_DIV [SINE_TERMS] = '{72, 42, 20, 6};
  localparam int EXP_DIV  [EXP_TERMS]  = '{7, 6, 5, 4, 3, 2, 1};

  // Pipeline depths of the lanes.
  localparam int SINE_STAGES  = 3 * SINE_TERMS + 4;
  localparam int POW_STAGES   = LOG_FRAC_BITS + 3 * EXP_TERMS + 6;
  localparam int PLACE_STAGES = 2;
  localparam int TOTAL_STAGES = SINE_STAGES + POW_STAGES + PLACE_STAGES;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SEMI_AXIS_X,
    CFG_SEMI_AXIS_Y,
    CFG_EXPONENT_X,
    CFG_EXPONENT_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== sv/spg_cdiv.sv =====
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Used by the series evaluations of the sine and power lanes; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module spg_cdiv #(
  parameter int XW      = 32,
  parameter int DIVISOR = 6
) (
  input  logic          clk,
  input  logic [1:0]    en,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] q
);

  // floor(2^XW / DIVISOR) undershoots the quotient by at most one.
  localparam logic [XW:0]   RECIP = (XW+1)'((65'd1 << XW) / DIVISOR);
  localparam logic [XW-1:0] DIV_V = XW'(DIVISOR);

  logic [XW-1:0] x_r;
  logic [2*XW:0] p_r;
  logic [XW-1:0] q_r;
  logic [XW-1:0] q0;
  logic [XW-1:0] rem;

  // First stage: multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= x;
      p_r <= x * RECIP;
    end
  end

  // Second stage: add one where the remainder still reaches the divisor.
  assign q0  = p_r[2*XW-1:XW];
  assign rem = x_r - XW'(q0 * DIV_V);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q_r <= q0 + {{(XW-1){1'b0}}, (rem >= DIV_V)};
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== sv/spg_sine.sv =====
// Sine lane: sin(f * pi/2) by a Horner Taylor series in Q30, rounded to Q1.FB.
// Depends on spg_pkg and spg_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module spg_sine
  import spg_pkg::*;
(
  input  logic                   clk,
  input  logic [SINE_STAGES-1:0] en,
  input  logic [Q_W-1:0]         f_in,
  output logic [MAG_W-1:0]       mag
);

  localparam int KF = 2 + 3 * SINE_TERMS;

  logic [Q_W-1:0]   z_r  [SINE_STAGES];
  logic [31:0]      z2_r [1:SINE_STAGES-1];
  logic [31:0]      x_r  [SINE_TERMS];
  logic [31:0]      q    [SINE_TERMS];
  logic [Q_W-1:0]   h    [SINE_TERMS+1];
  logic [2*Q_W-1:0] zp;
  logic [2*Q_W-1:0] zz;
  logic [2*Q_W-1:0] rp;
  logic [31:0]      r_r;
  logic [32:0]      rnd;
  logic [MAG_W-1:0] mag_r;

  // Scale the quarter-turn fraction to radians, then square.
  assign zp = f_in * Q_HALF_PI;
  assign zz = z_r[0] * z_r[0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z_r[0] <= zp[2*Q_W-2:30];
    end
    if (en[1]) begin
      z2_r[1] <= zz[2*Q_W-1:30];
    end
    for (int k = 1; k < SINE_STAGES; k++) begin
      if (en[k]) begin
        z_r[k] <= z_r[k-1];
      end
    end
    for (int k = 2; k < SINE_STAGES; k++) begin
      if (en[k]) begin
        z2_r[k] <= z2_r[k-1];
      end
    end
  end

  // One multiply and one constant division per series term.
  assign h[0] = Q_ONE;

  for (genvar i = 0; i < SINE_TERMS; i++) begin : g_term
    localparam int KM = 2 + 3 * i;
    logic [62:0] xp;

    assign xp = z2_r[KM-1] * h[i];

    always_ff @(posedge clk) begin
      if (en[KM]) begin
        x_r[i] <= xp[61:30];
      end
    end

    spg_cdiv #(
      .XW      (32),
      .DIVISOR (SINE_DIV[i])
    ) u_div (
      .clk (clk),
      .en  (en[KM+2:KM+1]),
      .x   (x_r[i]),
      .q   (q[i])
    );

    assign h[i+1] = Q_ONE - q[i][Q_W-1:0];
  end

  // Final multiply by z, then round half up and clamp to one.
  assign rp  = z_r[KF-1] * h[SINE_TERMS];
  assign rnd = {1'b0, r_r} + 33'(1 << (29 - FB));

  always_ff @(posedge clk) begin
    if (en[KF]) begin
      r_r <= rp[2*Q_W-1:30];
    end
    if (en[KF+1]) begin
      if ((rnd >> (30 - FB)) > 33'(1 << FB)) begin
        mag_r <= MAG_W'(1 << FB);
      end else begin
        mag_r <= MAG_W'(rnd >> (30 - FB));
      end
    end
  end

  assign mag = mag_r;

endmodule

`default_nettype wire

// ===== sv/spg_power.sv =====
// Power lane: mag^e as 2^(-e * log2(1/mag)) with a squaring logarithm
// and a Horner exponential series. Depends on spg_pkg and spg_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module spg_power
  import spg_pkg::*;
(
  input  logic                  clk,
  input  logic [POW_STAGES-1:0] en,
  input  logic [MAG_W-1:0]      mag_in,
  input  logic [EXP_W-1:0]      expo,
  output logic [MAG_W-1:0]      pw
);

  localparam int LF = LOG_FRAC_BITS;
  localparam int KL = LF + 1;
  localparam int KP = LF + 2;
  localparam int KT = LF + 3;
  localparam int KH = KT + 1 + 3 * EXP_TERMS;
  localparam int KO = KH + 1;

  logic                     zf_r   [POW_STAGES];
  logic [SHW-1:0]           sh_r   [0:LF];
  logic [MAG_W-1:0]         y_r    [0:LF];
  logic [LF-1:0]            frac_r [0:LF];
  logic [LGW-1:0]           lg_r;
  logic [PW-1:0]            p_r;
  logic [29:0]              t_r    [KT:POW_STAGES-1];
  logic [IPW-1:0]           ip_r   [KT:POW_STAGES-1];
  logic [29:0]              x_r    [EXP_TERMS];
  logic [29:0]              q      [EXP_TERMS];
  logic [Q_W-1:0]           h      [EXP_TERMS+1];
  logic [Q_W-1:0]           hf_r;
  logic [MAG_W-1:0]         pw_r;
  logic [SHW-1:0]           msb;
  logic [SHW-1:0]           sh0;
  logic [LGW+EXP_W-1:0]     lp;
  logic [LF+29:0]           gp;
  logic [IPW:0]             shift;
  logic [Q_W-1:0]           tmp;
  logic [Q_W:0]             rnd;

  // Leading one of the magnitude and the normalizing shift.
  always_comb begin
    msb = '0;
    for (int i = 0; i <= FB; i++) begin
      if (mag_in[i]) begin
        msb = SHW'(i);
      end
    end
    sh0 = SHW'(FB) - msb;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zf_r[0]   <= (mag_in == '0);
      sh_r[0]   <= sh0;
      y_r[0]    <= mag_in << sh0;
      frac_r[0] <= '0;
    end
    for (int k = 1; k < POW_STAGES; k++) begin
      if (en[k]) begin
        zf_r[k] <= zf_r[k-1];
      end
    end
    for (int k = 1; k <= LF; k++) begin
      if (en[k]) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  // One fraction bit of the logarithm per squaring.
  for (genvar k = 1; k <= LF; k++) begin : g_sq
    logic [2*MAG_W-1:0] ysq;
    logic [MAG_W:0]     yt;

    assign ysq = y_r[k-1] * y_r[k-1];
    assign yt  = ysq[2*MAG_W-1:FB];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (yt[MAG_W]) begin
          y_r[k]    <= yt[MAG_W:1];
          frac_r[k] <= {frac_r[k-1][LF-2:0], 1'b1};
        end else begin
          y_r[k]    <= yt[MAG_W-1:0];
          frac_r[k] <= {frac_r[k-1][LF-2:0], 1'b0};
        end
      end
    end
  end

  // Logarithm, scaled by the exponent, then the fraction scaled by ln2.
  assign lp = lg_r * expo;
  assign gp = p_r[LF-1:0] * Q_LN2;

  always_ff @(posedge clk) begin
    if (en[KL]) begin
      lg_r <= {sh_r[LF], {LF{1'b0}}} - LGW'(frac_r[LF]);
    end
    if (en[KP]) begin
      p_r <= lp[LGW+EXP_W-1:EXP_FRAC];
    end
    if (en[KT]) begin
      t_r[KT]  <= gp[LF+29:LF];
      ip_r[KT] <= p_r[PW-1:LF];
    end
    for (int k = KT + 1; k < POW_STAGES; k++) begin
      if (en[k]) begin
        t_r[k]  <= t_r[k-1];
        ip_r[k] <= ip_r[k-1];
      end
    end
  end

  // Exponential series, one multiply and one constant division per term.
  assign h[0] = Q_ONE;

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int KM = KT + 1 + 3 * j;
    logic [60:0] xp;

    assign xp = t_r[KM-1] * h[j];

    always_ff @(posedge clk) begin
      if (en[KM]) begin
        x_r[j] <= xp[59:30];
      end
    end

    spg_cdiv #(
      .XW      (30),
      .DIVISOR (EXP_DIV[j])
    ) u_div (
      .clk (clk),
      .en  (en[KM+2:KM+1]),
      .x   (x_r[j]),
      .q   (q[j])
    );

    assign h[j+1] = Q_ONE - {1'b0, q[j]};
  end

  // Scale by the integer part of the logarithm with round half up.
  assign shift = {1'b0, ip_r[KO-1]} + (IPW+1)'(30 - FB);
  assign tmp   = hf_r >> (shift - 1'b1);
  assign rnd   = {1'b0, tmp} + 1'b1;

  always_ff @(posedge clk) begin
    if (en[KH]) begin
      hf_r <= h[EXP_TERMS];
    end
    if (en[KO]) begin
      if (zf_r[KO-1] || (shift >= (IPW+1)'(40))) begin
        pw_r <= '0;
      end else begin
        pw_r <= rnd[MAG_W:1];
      end
    end
  end

  assign pw = pw_r;

endmodule

`default_nettype wire

// ===== sv/superellipse_point_generator_unit.sv =====
// Top level of the superellipse point generator: registers, lanes, placement.
// Depends on spg_pkg, spg_sine, spg_power and spg_cdiv.
//
// Each accepted angle yields one point (x, y) on the configured superellipse.
// The block is a fully pipelined datapath that takes one angle per clock and
// delivers one point per clock while the output side is ready. The pipeline
// is made of the sine lane (16 stages), the power lane (43 stages, among them
// one per squaring of the logarithm and three per series term) and two
// placement stages. Every stage has its own valid bit, so empty stages close
// up while the output waits and new angles are still taken until the pipeline
// is full. Configuration writes are taken at any time but must only be made
// while no point is in flight.
`timescale 1ns / 1ps
`default_nettype none

module superellipse_point_generator_unit
  import spg_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PHASE_BITS-1:0]  in_angle_phase,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [PT_W-1:0] out_point_x,
  output logic signed [PT_W-1:0] out_point_y,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int N  = TOTAL_STAGES;
  localparam int S  = SINE_STAGES;
  localparam int PA = SINE_STAGES + POW_STAGES;

  logic [AXIS_W-1:0] axis_x_r, axis_y_r, center_x_r, center_y_r;
  logic [EXP_W-1:0]  expo_x_r, expo_y_r;
  logic [N-1:0]      vld_r;
  logic [N-1:0]      rdy;
  logic [1:0]        quad_r [0:N-2];
  logic [29:0]       f30;
  logic [Q_W-1:0]    f_lo, f_hi;
  logic [MAG_W-1:0]  s_lo, s_hi, cmag, smag, pw_x, pw_y;
  logic [MAG_W+AXIS_W-1:0] offp_x, offp_y;
  logic [AXIS_W-1:0] off_x_r, off_y_r;
  logic [PT_W-1:0]   point_x_r, point_y_r;
  logic              cneg, sneg;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r   <= AXIS_W'(150);
      axis_y_r   <= AXIS_W'(150);
      expo_x_r   <= EXP_W'(11703);
      expo_y_r   <= EXP_W'(11703);
      center_x_r <= AXIS_W'(200);
      center_y_r <= AXIS_W'(200);
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SEMI_AXIS_X: axis_x_r   <= cfg_data[AXIS_W-1:0];
        CFG_SEMI_AXIS_Y: axis_y_r   <= cfg_data[AXIS_W-1:0];
        CFG_EXPONENT_X:  expo_x_r   <= cfg_data[EXP_W-1:0];
        CFG_EXPONENT_Y:  expo_y_r   <= cfg_data[EXP_W-1:0];
        CFG_CENTER_X:    center_x_r <= cfg_data[AXIS_W-1:0];
        CFG_CENTER_Y:    center_y_r <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when the output is taken or when it or any stage after it is empty.
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = out_ready | ~(&vld_r[N-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[N-1];

  // The quadrant travels beside the data.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      quad_r[0] <= in_angle_phase[PHASE_BITS-1:PHASE_BITS-2];
    end
    for (int k = 1; k < N - 1; k++) begin
      if (rdy[k]) begin
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  // Angle within the quadrant and its complement.
  assign f30  = {in_angle_phase[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}};
  assign f_lo = {1'b0, f30};
  assign f_hi = Q_ONE - f_lo;

  spg_sine u_sine_lo (
    .clk  (clk),
    .en   (rdy[S-1:0]),
    .f_in (f_lo),
    .mag  (s_lo)
  );

  spg_sine u_sine_hi (
    .clk  (clk),
    .en   (rdy[S-1:0]),
    .f_in (f_hi),
    .mag  (s_hi)
  );

  // Odd quadrants swap the roles of the two sine lanes.
  assign cmag = quad_r[S-1][0] ? s_lo : s_hi;
  assign smag = quad_r[S-1][0] ? s_hi : s_lo;

  spg_power u_pow_x (
    .clk    (clk),
    .en     (rdy[PA-1:S]),
    .mag_in (cmag),
    .expo   (expo_x_r),
    .pw     (pw_x)
  );

  spg_power u_pow_y (
    .clk    (clk),
    .en     (rdy[PA-1:S]),
    .mag_in (smag),
    .expo   (expo_y_r),
    .pw     (pw_y)
  );

  // Scale by the semi-axes.
  assign offp_x = pw_x * axis_x_r;
  assign offp_y = pw_y * axis_y_r;

  always_ff @(posedge clk) begin
    if (rdy[PA]) begin
      off_x_r <= offp_x[FB+AXIS_W-1:FB];
      off_y_r <= offp_y[FB+AXIS_W-1:FB];
    end
  end

  // Apply the signs of cos and sin and add the centre.
  assign cneg = quad_r[N-2][1] ^ quad_r[N-2][0];
  assign sneg = quad_r[N-2][1];

  always_ff @(posedge clk) begin
    if (rdy[N-1]) begin
      point_x_r <= cneg ? PT_W'(center_x_r) - PT_W'(off_x_r)
                        : PT_W'(center_x_r) + PT_W'(off_x_r);
      point_y_r <= sneg ? PT_W'(center_y_r) - PT_W'(off_y_r)
                        : PT_W'(center_y_r) + PT_W'(off_y_r);
    end
  end

  assign out_point_x = point_x_r;
  assign out_point_y = point_y_r;

endmodule

`default_nettype wire

// ===== sv/spg_checker.sv =====
// Port-level checks for the superellipse point generator, bound to its top.
// Depends on spg_pkg and superellipse_point_generator_unit.
`timescale 1ns / 1ps
`default_nettype none

module spg_checker
  import spg_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [PT_W-1:0] out_point_x,
  input logic signed [PT_W-1:0] out_point_y
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("point valid after reset");

  // A taken result lets every stage move, so an angle can enter.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  // An empty output stage means there is room at the input.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // A waiting point holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x)
                                && $stable(out_point_y))
    else $error("waiting point changed or dropped");

endmodule

bind superellipse_point_generator_unit spg_checker u_spg_checker (.*);

`default_nettype wire
